@@ rtl/ifd_pkg.sv @@
package ifd_pkg;

    // Header layout.
    localparam int unsigned HDR_BYTES = 8;
    localparam logic [7:0]  KIND_DATA = 8'd1;

    // Frame status codes.
    localparam logic [1:0] ST_OK    = 2'd0;
    localparam logic [1:0] ST_NEWER = 2'd1;
    localparam logic [1:0] ST_OLDER = 2'd2;
    localparam logic [1:0] ST_KIND  = 2'd3;

    // Result word kinds.
    localparam logic ITEM_DATA   = 1'b0;
    localparam logic ITEM_STATUS = 1'b1;

    // Configuration register indexes.
    localparam int unsigned CFG_IDX_W       = 1;
    localparam logic [0:0]  REG_MAX_PAYLOAD = 1'd0;
    localparam logic [0:0]  REG_OWN_VERSION = 1'd1;

    // Configuration reset values.
    localparam logic [31:0] MAX_PAYLOAD_RST = 32'hFFFF_FFFF;
    localparam logic [15:0] OWN_VERSION_RST = 16'd1;

    // Default depth of the result queue (power of two, at least 4).
    localparam int unsigned IFD_OUT_DEPTH = 4;

    // One result word.
    typedef struct packed {
        logic        item_kind;
        logic [7:0]  data_byte;
        logic [1:0]  frame_status;
        logic [15:0] peer_version;
        logic [31:0] delivered_length;
        logic        truncated;
        logic        last;
    } t_result;

    // Results produced by one input word: zero, one or two.
    typedef struct packed {
        logic [1:0] n;
        t_result    r0;
        t_result    r1;
    } t_push;

endpackage

@@ rtl/ifd_ifs.sv @@
// Input byte channel.
interface ifd_rx_if;
    logic       valid;
    logic       ready;
    logic [7:0] rx_byte;

    modport source (output valid, output rx_byte, input ready);
    modport sink   (input valid, input rx_byte, output ready);
endinterface

// Result channel.
interface ifd_res_if;
    logic        valid;
    logic        ready;
    logic        item_kind;
    logic [7:0]  data_byte;
    logic [1:0]  frame_status;
    logic [15:0] peer_version;
    logic [31:0] delivered_length;
    logic        truncated;
    logic        last;

    modport source (output valid, output item_kind, output data_byte, output frame_status,
                    output peer_version, output delivered_length, output truncated,
                    output last, input ready);
    modport sink   (input valid, input item_kind, input data_byte, input frame_status,
                    input peer_version, input delivered_length, input truncated,
                    input last, output ready);
endinterface

// Configuration write channel.
interface ifd_cfg_if;
    logic        valid;
    logic        ready;
    logic [0:0]  index;
    logic [31:0] data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

@@ rtl/ifd_out_fifo.sv @@
module ifd_out_fifo
    import ifd_pkg::*;
#(
    parameter int unsigned DEPTH = IFD_OUT_DEPTH
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  t_push             i_push,
    output logic              o_room,
    ifd_res_if.source         o_res
);

    localparam int unsigned PTR_W = $clog2(DEPTH);
    localparam int unsigned CNT_W = $clog2(DEPTH + 1);

    t_result              r_mem [DEPTH];
    logic [PTR_W-1:0]     r_wr_ptr;
    logic [PTR_W-1:0]     r_rd_ptr;
    logic [CNT_W-1:0]     r_count;
    logic [PTR_W-1:0]     n_wr_ptr;
    logic [PTR_W-1:0]     wr_ptr_p1;
    logic [CNT_W-1:0]     n_count;
    logic                 pop;
    t_result              head;

    // Room for the two words one input word can produce.
    assign o_room = (r_count <= CNT_W'(DEPTH - 2));

    assign pop       = o_res.valid && o_res.ready;
    assign wr_ptr_p1 = r_wr_ptr + PTR_W'(1);
    assign n_wr_ptr  = r_wr_ptr + PTR_W'(i_push.n);
    assign n_count   = r_count + CNT_W'(i_push.n) - CNT_W'(pop);

    // Queue storage, up to two writes per cycle at consecutive entries.
    always_ff @(posedge i_clk) begin
        if (i_push.n != 2'd0) begin
            r_mem[r_wr_ptr] <= i_push.r0;
        end
        if (i_push.n == 2'd2) begin
            r_mem[wr_ptr_p1] <= i_push.r1;
        end
    end

    // Pointers and fill count.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_count  <= n_count;
            if (pop) begin
                r_rd_ptr <= r_rd_ptr + PTR_W'(1);
            end
        end
    end

    // Head of the queue drives the result channel.
    assign head                   = r_mem[r_rd_ptr];
    assign o_res.valid            = (r_count != '0);
    assign o_res.item_kind        = head.item_kind;
    assign o_res.data_byte        = head.data_byte;
    assign o_res.frame_status     = head.frame_status;
    assign o_res.peer_version     = head.peer_version;
    assign o_res.delivered_length = head.delivered_length;
    assign o_res.truncated        = head.truncated;
    assign o_res.last             = head.last;

endmodule

@@ rtl/ipc_frame_deframer.sv @@
// Result words are registered in the result queue and offered from its head in order.
// Throughput: one input word per cycle; a word closing a delivered payload makes two
// result words, and input ready drops while the result queue has under two free entries.
// Reset: synchronous, active low; clears the frame parser, the queue and sets
// max_payload to all ones and own_version to one.
module ipc_frame_deframer
    import ifd_pkg::*;
#(
    parameter int unsigned OUT_DEPTH = IFD_OUT_DEPTH
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    ifd_rx_if.sink    i_rx,
    ifd_res_if.source o_res,
    ifd_cfg_if.sink   i_cfg
);

    // Configuration registers.
    logic [31:0] r_max_payload;
    logic [15:0] r_own_version;

    // Frame parser state.
    logic [2:0]  r_hdr_cnt;
    logic        r_in_payload;
    logic [15:0] r_version;
    logic [7:0]  r_kind;
    logic [23:0] r_len;
    logic [31:0] r_remaining;
    logic [31:0] r_delivered;
    logic [1:0]  r_status;
    logic        r_skipped;

    logic        n_in_payload;
    logic [31:0] n_remaining;
    logic [31:0] n_delivered;
    logic [1:0]  n_status;
    logic        n_skipped;

    logic        accept;
    logic        room;
    logic [7:0]  rx_b;
    logic [31:0] full_len;
    logic        len_empty;
    logic [31:0] pay_len;
    logic        deliver;
    logic        pay_close;
    t_push       push;
    t_result     data_res;
    t_result     stat_res;

    assign i_cfg.ready = 1'b1;
    assign i_rx.ready  = room;
    assign accept      = i_rx.valid && room;
    assign rx_b        = i_rx.rx_byte;

    // Configuration writes.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_max_payload <= MAX_PAYLOAD_RST;
            r_own_version <= OWN_VERSION_RST;
        end else if (i_cfg.valid) begin
            unique case (i_cfg.index)
                REG_MAX_PAYLOAD: r_max_payload <= i_cfg.data;
                REG_OWN_VERSION: r_own_version <= i_cfg.data[15:0];
                default: ;
            endcase
        end
    end

    // Full length as completed by the last header byte, and the payload length.
    assign full_len  = {r_len, rx_b};
    assign len_empty = (full_len <= 32'(HDR_BYTES));
    assign pay_len   = len_empty ? 32'd0 : full_len - 32'(HDR_BYTES);

    // Status from the version and kind fields of a complete header.
    always_comb begin
        priority if (r_version > r_own_version) begin
            n_status = ST_NEWER;
        end else if (r_version < r_own_version) begin
            n_status = ST_OLDER;
        end else if (r_kind != KIND_DATA) begin
            n_status = ST_KIND;
        end else begin
            n_status = ST_OK;
        end
    end

    // Payload byte handling.
    assign deliver     = (r_status == ST_OK) && (r_delivered < r_max_payload);
    assign n_delivered = r_delivered + 32'(deliver);
    assign n_skipped   = r_skipped || ((r_status == ST_OK) && !deliver);
    assign pay_close   = (r_remaining == 32'd1);
    assign n_remaining = r_remaining - 32'd1;

    // Result words for this input word.
    always_comb begin
        data_res                  = '0;
        data_res.item_kind        = ITEM_DATA;
        data_res.data_byte        = rx_b;
        data_res.frame_status     = ST_OK;
        data_res.peer_version     = r_version;
        data_res.delivered_length = n_delivered;

        stat_res                  = '0;
        stat_res.item_kind        = ITEM_STATUS;
        stat_res.peer_version     = r_version;
        stat_res.last             = 1'b1;
        if (r_in_payload) begin
            stat_res.frame_status     = r_status;
            stat_res.delivered_length = n_delivered;
            stat_res.truncated        = n_skipped && (r_status == ST_OK);
        end else begin
            stat_res.frame_status     = n_status;
            stat_res.delivered_length = 32'd0;
            stat_res.truncated        = 1'b0;
        end

        push    = '0;
        push.r0 = data_res;
        push.r1 = stat_res;
        if (accept) begin
            if (r_in_payload) begin
                push.n = 2'(deliver) + 2'(pay_close);
                if (!deliver) begin
                    push.r0 = stat_res;
                end
            end else if ((r_hdr_cnt == 3'(HDR_BYTES - 1)) && len_empty) begin
                push.n  = 2'd1;
                push.r0 = stat_res;
            end
        end
    end

    // Next payload-phase flag.
    always_comb begin
        n_in_payload = r_in_payload;
        if (accept) begin
            if (r_in_payload) begin
                n_in_payload = !pay_close;
            end else if (r_hdr_cnt == 3'(HDR_BYTES - 1)) begin
                n_in_payload = !len_empty;
            end
        end
    end

    // Parser registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_hdr_cnt    <= '0;
            r_in_payload <= 1'b0;
            r_version    <= '0;
            r_kind       <= '0;
            r_len        <= '0;
            r_remaining  <= '0;
            r_delivered  <= '0;
            r_status     <= ST_OK;
            r_skipped    <= 1'b0;
        end else if (accept) begin
            r_in_payload <= n_in_payload;
            if (r_in_payload) begin
                r_delivered <= n_delivered;
                r_skipped   <= n_skipped;
                r_remaining <= n_remaining;
            end else begin
                r_hdr_cnt <= r_hdr_cnt + 3'd1;
                unique case (r_hdr_cnt)
                    3'd0: begin
                        r_version[15:8] <= rx_b;
                        r_delivered     <= '0;
                        r_skipped       <= 1'b0;
                    end
                    3'd1: r_version[7:0] <= rx_b;
                    3'd2: r_kind <= rx_b;
                    3'd3: ;
                    default: r_len <= full_len[23:0];
                endcase
                if (r_hdr_cnt == 3'(HDR_BYTES - 1)) begin
                    r_status    <= n_status;
                    r_remaining <= pay_len;
                end
            end
        end
    end

    // Result queue.
    ifd_out_fifo #(
        .DEPTH (OUT_DEPTH)
    ) u_out_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .o_room  (room),
        .o_res   (o_res)
    );

endmodule

@@ rtl/ifd_checker.sv @@
module ifd_checker
    import ifd_pkg::*;
(
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        i_out_valid,
    input logic        i_out_ready,
    input logic        i_item_kind,
    input logic [7:0]  i_data_byte,
    input logic [1:0]  i_frame_status,
    input logic [31:0] i_delivered_length,
    input logic        i_truncated,
    input logic        i_last
);

    // A stalled result word stays valid and holds its byte, kind and delivered length.
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> i_out_valid && $stable(i_data_byte)
            && $stable(i_item_kind) && $stable(i_delivered_length))
    else $error("result word changed while stalled");

    // Payload words carry a byte and nothing of the frame status.
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && (i_item_kind == ITEM_DATA) |->
            !i_last && !i_truncated && (i_frame_status == ST_OK)
            && (i_delivered_length != 32'd0))
    else $error("malformed payload word");

    // Status words close the frame and carry no byte.
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && (i_item_kind == ITEM_STATUS) |-> i_last && (i_data_byte == 8'd0))
    else $error("malformed status word");

    // Only an accepted frame can report truncation.
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && i_truncated |-> (i_frame_status == ST_OK))
    else $error("truncation reported on a rejected frame");

endmodule

bind ipc_frame_deframer ifd_checker u_ifd_checker (
    .i_clk              (i_clk),
    .i_rst_n            (i_rst_n),
    .i_out_valid        (o_res.valid),
    .i_out_ready        (o_res.ready),
    .i_item_kind        (o_res.item_kind),
    .i_data_byte        (o_res.data_byte),
    .i_frame_status     (o_res.frame_status),
    .i_delivered_length (o_res.delivered_length),
    .i_truncated        (o_res.truncated),
    .i_last             (o_res.last)
);
